FILE: hdl/gha_pkg.sv
// Shared types, constants and helper functions for the GHASH accumulator.
// Used by the channel interfaces, the input stage, the multiplier and the top level.
package gha_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_W     = 128;
  localparam int WORD_W      = 64;
  localparam int CNT_W       = 61;
  localparam int LEN_SHIFT   = 3;
  localparam int NBYTES_W    = 5;
  localparam int ACTION_W    = 2;
  localparam int CFG_IDX_W   = 2;

  // Action codes of an input item. The fourth code is unused and ignored.
  typedef enum logic [ACTION_W-1:0] {
    ACT_AAD    = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  // Contents of the input register, handed from the input stage to the core.
  typedef struct packed {
    logic                valid;
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  block;
    logic [NBYTES_W-1:0] nbytes;
  } stage_t;

  // Keeps the first n bytes of a big-endian 128-bit block, n at most 16.
  function automatic logic [BLOCK_W-1:0] lead_mask(input logic [NBYTES_W-1:0] n);
    logic [BLOCK_W-1:0] m;
    m = '0;
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      m[BLOCK_W-1-8*b -: 8] = (NBYTES_W'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hdl/gha_intf.sv
// Valid/ready channel interfaces of the GHASH accumulator: input items,
// result items and configuration writes. Depends on gha_pkg.
interface gha_blk_if import gha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   block_high;
  logic [WORD_W-1:0]   block_low;
  logic [NBYTES_W-1:0] valid_bytes;
  modport source (output valid, action, block_high, block_low, valid_bytes, input ready);
  modport sink   (input valid, action, block_high, block_low, valid_bytes, output ready);
endinterface

interface gha_tag_if import gha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] tag_high;
  logic [WORD_W-1:0] tag_low;
  modport source (output valid, tag_high, tag_low, input ready);
  modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

interface gha_cfg_if import gha_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/gha_in_stage.sv
// Input register of the GHASH accumulator: clamps the byte count and zero-pads the block.
// Depends on gha_pkg and gha_blk_if.
module gha_in_stage import gha_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gha_blk_if.sink       blk_i,
  input  logic          advance_i,
  output stage_t        stage_o
);

  logic                valid_q, valid_d;
  logic [ACTION_W-1:0] action_q;
  logic [BLOCK_W-1:0]  block_q;
  logic [NBYTES_W-1:0] nbytes_q;
  logic [NBYTES_W-1:0] n_clamp;
  logic                accept;

  assign blk_i.ready = !valid_q || advance_i;
  assign accept      = blk_i.valid && blk_i.ready;

  // Counts above a full block are treated as a full block.
  assign n_clamp = (blk_i.valid_bytes > NBYTES_W'(BLOCK_BYTES)) ?
                   NBYTES_W'(BLOCK_BYTES) : blk_i.valid_bytes;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= blk_i.action;
      block_q  <= {blk_i.block_high, blk_i.block_low} & lead_mask(n_clamp);
      nbytes_q <= n_clamp;
    end
  end

  assign stage_o = '{valid: valid_q, action: action_q, block: block_q, nbytes: nbytes_q};

endmodule

FILE: hdl/gha_gf_mult.sv
// Combinational GF(2^128) multiplier in GCM bit order (first bit is the x^0 coefficient),
// reduced by x^128 + x^7 + x^2 + x + 1. Depends on gha_pkg.
module gha_gf_mult import gha_pkg::*; (
  input  logic [BLOCK_W-1:0] a_i,
  input  logic [BLOCK_W-1:0] b_i,
  output logic [BLOCK_W-1:0] p_o
);

  localparam int PROD_W = 2 * BLOCK_W - 1;
  localparam int HI_W   = PROD_W - BLOCK_W;
  localparam int F1_W   = BLOCK_W + 6;

  logic [BLOCK_W-1:0] ar, br, rr;
  logic [PROD_W-1:0]  prod;
  logic [HI_W-1:0]    hi;
  logic [F1_W-1:0]    f1;
  logic [5:0]         hi2;

  // Reverse so that vector bit k is the coefficient of x^k.
  always_comb begin
    for (int i = 0; i < BLOCK_W; i++) begin
      ar[i] = a_i[BLOCK_W-1-i];
      br[i] = b_i[BLOCK_W-1-i];
    end
  end

  // Carry-less product; each output coefficient is its own XOR tree.
  always_comb begin
    for (int k = 0; k < PROD_W; k++) begin
      prod[k] = 1'b0;
      for (int i = 0; i < BLOCK_W; i++) begin
        if (k - i >= 0 && k - i < BLOCK_W) begin
          prod[k] = prod[k] ^ (ar[i] & br[k-i]);
        end
      end
    end
  end

  // Two folds of the upper half: x^128 = x^7 + x^2 + x + 1.
  always_comb begin
    hi  = prod[PROD_W-1:BLOCK_W];
    f1  = {6'b0, prod[BLOCK_W-1:0]} ^ {hi, 7'b0} ^ {5'b0, hi, 2'b0}
        ^ {6'b0, hi, 1'b0} ^ {7'b0, hi};
    hi2 = f1[F1_W-1:BLOCK_W];
    rr  = f1[BLOCK_W-1:0] ^ {115'b0, hi2, 7'b0} ^ {120'b0, hi2, 2'b0}
        ^ {121'b0, hi2, 1'b0} ^ {122'b0, hi2};
  end

  always_comb begin
    for (int i = 0; i < BLOCK_W; i++) begin
      p_o[i] = rr[BLOCK_W-1-i];
    end
  end

endmodule

FILE: hdl/ghash_accumulator_core.sv
// Top level of the GHASH accumulator: key and state registers, length counters, tag register.
// Depends on gha_pkg, the channel interfaces, gha_in_stage and gha_gf_mult.
//
// Usage. The hash key H is written through cfg_i: index 0 sets its first eight bytes,
// index 1 its last eight; other indexes are ignored and the port is always ready. Keys
// must be written only while no item is in flight; the block does not enforce this. Each item
// on blk_i is an AAD block, a text block or a finish request. An absorb block is zero-padded
// after valid_bytes bytes (counts above 16 act as 16, zero leaves everything unchanged),
// XORed into the running hash and multiplied by H. A finish item absorbs the bit lengths of
// AAD and text, sends the tag out on tag_o and clears the hash and both byte counts.
//
// Timing. An item waits in the input register until it can move on; the full GF(2^128)
// multiply is combinational from that register into the accumulator, so a new item is
// taken on every cycle unless a finish item waits for the tag register. The tag of a
// finish item is valid in the cycle after the item leaves the input register.
//
// Stalls. While the tag register holds an unaccepted tag, absorb items keep flowing;
// a following finish item waits in the input register and blk_i.ready drops until the
// tag is taken. Reset clears the key, the hash, the counts and all valid flags.
module ghash_accumulator_core import gha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  gha_cfg_if.sink  cfg_i,
  gha_blk_if.sink  blk_i,
  gha_tag_if.source tag_o
);

  stage_t             stage;
  logic               advance;
  logic               is_finish;
  logic               is_absorb;
  logic               out_free;
  logic [BLOCK_W-1:0] operand;
  logic [BLOCK_W-1:0] mult_out;

  logic [WORD_W-1:0]  key_hi_q, key_hi_d;
  logic [WORD_W-1:0]  key_lo_q, key_lo_d;
  logic [BLOCK_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]   aad_cnt_q, aad_cnt_d;
  logic [CNT_W-1:0]   txt_cnt_q, txt_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [BLOCK_W-1:0] tag_q;

  gha_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_i     (blk_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // A finish item needs a free tag register; everything else always moves on.
  assign out_free  = !out_valid_q || tag_o.ready;
  assign is_finish = stage.action == ACT_FINISH;
  assign is_absorb = (stage.action == ACT_AAD || stage.action == ACT_TEXT)
                     && (stage.nbytes != '0);
  assign advance   = stage.valid && (!is_finish || out_free);

  // The finish block is len(A) || len(C) in bits.
  assign operand = is_finish ?
                   {aad_cnt_q, {LEN_SHIFT{1'b0}}, txt_cnt_q, {LEN_SHIFT{1'b0}}} :
                   stage.block;

  gha_gf_mult u_gf_mult (
    .a_i (acc_q ^ operand),
    .b_i ({key_hi_q, key_lo_q}),
    .p_o (mult_out)
  );

  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_KEY_HIGH) begin
        key_hi_d = cfg_i.data;
      end
      if (cfg_i.index == REG_KEY_LOW) begin
        key_lo_d = cfg_i.data;
      end
    end
  end

  always_comb begin
    acc_d       = acc_q;
    aad_cnt_d   = aad_cnt_q;
    txt_cnt_d   = txt_cnt_q;
    out_valid_d = out_valid_q && !tag_o.ready;
    if (advance) begin
      if (is_finish) begin
        acc_d       = '0;
        aad_cnt_d   = '0;
        txt_cnt_d   = '0;
        out_valid_d = 1'b1;
      end else if (is_absorb) begin
        acc_d = mult_out;
        if (stage.action == ACT_AAD) begin
          aad_cnt_d = aad_cnt_q + CNT_W'(stage.nbytes);
        end else begin
          txt_cnt_d = txt_cnt_q + CNT_W'(stage.nbytes);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      acc_q       <= '0;
      aad_cnt_q   <= '0;
      txt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      key_hi_q    <= key_hi_d;
      key_lo_q    <= key_lo_d;
      acc_q       <= acc_d;
      aad_cnt_q   <= aad_cnt_d;
      txt_cnt_q   <= txt_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_finish) begin
      tag_q <= mult_out;
    end
  end

  assign tag_o.valid    = out_valid_q;
  assign tag_o.tag_high = tag_q[BLOCK_W-1:WORD_W];
  assign tag_o.tag_low  = tag_q[WORD_W-1:0];

endmodule

FILE: hdl/gha_checker.sv
// Port-level checks for the GHASH accumulator and the bind that attaches them.
// Depends on gha_pkg and ghash_accumulator_core.
module gha_checker import gha_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                blk_valid_i,
  input logic                blk_ready_i,
  input logic [ACTION_W-1:0] blk_action_i,
  input logic                tag_valid_i,
  input logic                tag_ready_i
);

  logic finish_acc;
  assign finish_acc = blk_valid_i && blk_ready_i && (blk_action_i == ACT_FINISH);

  // A pending tag stays offered until it is taken.
  a_tag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_valid_i && !tag_ready_i |=> tag_valid_i)
    else $error("tag dropped before it was taken");

  // A fresh tag appears only for a finish item that was accepted and passed the input register.
  a_tag_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tag_valid_i) |-> $past(finish_acc, 2))
    else $error("tag appeared without a matching finish item");

  // The input side only stalls behind a tag that the receiver holds off.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blk_ready_i |-> tag_valid_i && !tag_ready_i)
    else $error("input stalled while the tag register was free");

endmodule

bind ghash_accumulator_core gha_checker u_gha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .blk_valid_i  (blk_i.valid),
  .blk_ready_i  (blk_i.ready),
  .blk_action_i (blk_i.action),
  .tag_valid_i  (tag_o.valid),
  .tag_ready_i  (tag_o.ready)
);
